@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions on a clock with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/mwfr_pkg.sv @@
// ---------------------------------------------------------------------------
// mwfr_pkg
// Constants, codes and helper functions of the write-frame receiver.
// ---------------------------------------------------------------------------
package mwfr_pkg;

	localparam int HEADER_BYTES  = 7;
	localparam int ACK_HDR_BYTES = 6;
	localparam int ACK_BEATS     = 8;
	localparam int POS_W         = 9;
	localparam int BEAT_W        = 3;
	localparam int REG_IDX_W     = 8;
	localparam int CFG_DATA_W    = 16;

	typedef logic [7:0]       byte_t;
	typedef logic [15:0]      word_t;
	typedef logic [2:0]       status_t;
	typedef logic [POS_W-1:0] pos_t;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_STATION_ADDRESS = 8'd0;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_REGISTER  = 8'd1;
	localparam logic [REG_IDX_W-1:0] REG_FINAL_REGISTER  = 8'd2;
	localparam logic [REG_IDX_W-1:0] REG_PAYLOAD_LIMIT   = 8'd3;

	// Frame status codes.
	localparam status_t STATUS_ACKED    = 3'd0;
	localparam status_t STATUS_FOREIGN  = 3'd1;
	localparam status_t STATUS_RANGE    = 3'd2;
	localparam status_t STATUS_TOO_LONG = 3'd3;
	localparam status_t STATUS_CRC      = 3'd4;
	localparam status_t STATUS_NO_ACK   = 3'd5;

	localparam byte_t FUNC_WRITE_MULTI = 8'h10;
	localparam byte_t TYPE_CLEAR_ALL   = 8'h77;

	localparam word_t OFF_CLEAR_A = 16'h0000;
	localparam word_t OFF_CLEAR_B = 16'h0003;
	localparam word_t OFF_CLEAR_C = 16'h0005;
	localparam word_t OFF_DISP_A  = 16'h0006;
	localparam word_t OFF_DISP_B  = 16'h0010;
	localparam word_t OFF_DISP_C  = 16'h0050;
	localparam word_t OFF_DISP_D  = 16'h0090;

	localparam word_t CRC_INIT = 16'hFFFF;
	localparam word_t CRC_POLY = 16'hA001;

	// One byte of CRC-16/Modbus, reflected, LSB first.
	function automatic word_t crc16_byte(input word_t crc_in, input byte_t b);
		word_t c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Payload types that have a known signal collection.
	function automatic logic known_type(input byte_t t);
		return (t == 8'h02) || (t == 8'h03) || (t == 8'h04) || (t == 8'h19) || (t == 8'h33);
	endfunction

endpackage

@@ sv/mwfr_ifs.sv @@
// ---------------------------------------------------------------------------
// mwfr channel interfaces
// Valid/ready channels for received items, results and register writes.
// ---------------------------------------------------------------------------
interface mwfr_item_if;
	import mwfr_pkg::*;
	logic  valid;
	logic  ready;
	logic  kind;
	byte_t rx_byte;
	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface mwfr_result_if;
	import mwfr_pkg::*;
	logic    valid;
	logic    ready;
	status_t frame_status;
	logic    ack_valid;
	byte_t   ack_byte;
	logic    ack_last;
	byte_t   data_type;
	byte_t   payload_len;
	word_t   register_offset;
	logic    clear_signals;
	logic    dispatch_payload;
	modport source (output valid, output frame_status, output ack_valid, output ack_byte,
		output ack_last, output data_type, output payload_len, output register_offset,
		output clear_signals, output dispatch_payload, input ready);
	modport sink (input valid, input frame_status, input ack_valid, input ack_byte,
		input ack_last, input data_type, input payload_len, input register_offset,
		input clear_signals, input dispatch_payload, output ready);
endinterface

interface mwfr_cfg_if;
	import mwfr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [REG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/modbus_write_frame_receiver_unit.sv @@
// ---------------------------------------------------------------------------
// modbus_write_frame_receiver_unit
// Assembles Modbus RTU write-multiple-registers frames from a byte stream,
// checks them and emits the status and the acknowledgement bytes.
// ---------------------------------------------------------------------------
//
// Channel   Role    Transaction carries
// item      sink    kind (byte or line gap), rx_byte
// result    source  frame_status, ack_valid/byte/last, type, length, offset, flags
// cfg       sink    index, data (register write, always ready)
//
// One item is taken per cycle unless a pending result job stalls the input
// register. An accepted item sits in the input register and is then folded
// into the frame state by a combinational step that includes the bytewise CRC.
// A result shows on the result channel once the item has passed the input
// and job registers. An acknowledgement occupies the result channel for eight
// transactions; meanwhile one further item waits in the input register. All
// control state is cleared by arst_n; nothing else is needed after reset.
module modbus_write_frame_receiver_unit (
	input logic             clk,
	input logic             arst_n,
	mwfr_item_if.sink       item,
	mwfr_result_if.source   result,
	mwfr_cfg_if.sink        cfg
);
	import mwfr_pkg::*;

	// Configuration registers.
	byte_t station_q;
	word_t first_q;
	word_t final_q;
	byte_t limit_q;

	// Input register.
	logic  valid_s1;
	logic  kind_s1;
	byte_t byte_s1;

	// Frame state.
	pos_t  pos_q;
	byte_t hdr_q [HEADER_BYTES];
	word_t crc_run_q;
	word_t crc_ack_q;
	byte_t type_q;
	byte_t len_q;
	byte_t crc_lo_q;

	// Result job: one status transaction, or eight acknowledgement beats.
	logic              job_valid_q;
	logic              job_ack_q;
	logic [BEAT_W-1:0] job_beat_q;
	status_t           job_status_q;
	byte_t             job_hdr_q [ACK_HDR_BYTES];
	word_t             job_crc_q;
	byte_t             job_type_q;
	byte_t             job_len_q;
	word_t             job_off_q;
	logic              job_clr_q;
	logic              job_disp_q;

	logic job_last;
	logic job_free;
	logic adv;

	// Step decode.
	logic    in_hdr;
	pos_t    data_end;
	word_t   crc_run_upd;
	word_t   crc_ack_upd;
	logic    hdr_done;
	logic    hdr_ok;
	logic    frame_done;
	byte_t   len_eff;
	word_t   reg_addr;
	word_t   off;
	word_t   crc_rx;
	logic    res_emit;
	logic    res_ack;
	logic    res_fields;
	status_t res_status;
	logic    res_clr;
	logic    res_disp;

	// The job slot frees when it is empty or its last transaction leaves now.
	assign job_last = !job_ack_q || (job_beat_q == BEAT_W'(ACK_BEATS - 1));
	assign job_free = !job_valid_q || (result.ready && job_last);
	assign adv      = valid_s1 && job_free;

	// The input register takes a new item when it is empty or its content moves on.
	assign item.ready = !valid_s1 || job_free;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= 8'd1;
			first_q   <= 16'h0000;
			final_q   <= 16'hFFFF;
			limit_q   <= 8'hFF;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_STATION_ADDRESS: station_q <= cfg.data[7:0];
				REG_FIRST_REGISTER:  first_q   <= cfg.data;
				REG_FINAL_REGISTER:  final_q   <= cfg.data;
				REG_PAYLOAD_LIMIT:   limit_q   <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			kind_s1 <= item.kind;
			byte_s1 <= item.rx_byte;
		end
	end

	// While the header is coming in, the data section has no length yet.
	assign in_hdr      = pos_q < POS_W'(HEADER_BYTES);
	assign data_end    = POS_W'(HEADER_BYTES) + (in_hdr ? '0 : {1'b0, hdr_q[HEADER_BYTES-1]});
	assign crc_run_upd = crc16_byte(crc_run_q, byte_s1);
	assign crc_ack_upd = crc16_byte(crc_ack_q, byte_s1);
	assign hdr_done    = pos_q == POS_W'(HEADER_BYTES - 1);
	assign hdr_ok      = (hdr_q[0] == station_q) && (hdr_q[1] == FUNC_WRITE_MULTI);
	assign frame_done  = !in_hdr && (pos_q == data_end + POS_W'(1));
	// With a byte count of zero the length byte is the CRC high byte now arriving.
	assign len_eff     = (pos_q == POS_W'(HEADER_BYTES + 1)) ? byte_s1 : len_q;
	assign reg_addr    = {hdr_q[2], hdr_q[3]};
	assign off         = reg_addr - first_q;
	assign crc_rx      = {byte_s1, crc_lo_q};

	always_comb begin
		res_emit   = 1'b0;
		res_ack    = 1'b0;
		res_fields = 1'b0;
		res_status = STATUS_ACKED;
		res_clr    = 1'b0;
		res_disp   = 1'b0;
		if (!kind_s1 && hdr_done && !hdr_ok) begin
			res_emit   = 1'b1;
			res_status = STATUS_FOREIGN;
		end else if (!kind_s1 && frame_done) begin
			res_emit = 1'b1;
			priority if ((reg_addr < first_q) || (reg_addr > final_q)) begin
				res_status = STATUS_RANGE;
			end else if (len_eff > limit_q) begin
				res_status = STATUS_TOO_LONG;
			end else if (crc_run_q != crc_rx) begin
				res_status = STATUS_CRC;
			end else if ((off == OFF_CLEAR_A) || (off == OFF_CLEAR_B) ||
					(off == OFF_CLEAR_C)) begin
				res_fields = 1'b1;
				res_ack    = 1'b1;
				res_clr    = type_q == TYPE_CLEAR_ALL;
			end else if ((off == OFF_DISP_A) || (off == OFF_DISP_B) ||
					(off == OFF_DISP_C) || (off == OFF_DISP_D)) begin
				res_fields = 1'b1;
				res_ack    = 1'b1;
				res_disp   = known_type(type_q);
			end else begin
				res_fields = 1'b1;
				res_status = STATUS_NO_ACK;
			end
		end
	end

	// Frame state: a line gap or any result returns the frame to its start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_run_q <= CRC_INIT;
			crc_ack_q <= CRC_INIT;
			type_q    <= '0;
			len_q     <= '0;
			crc_lo_q  <= '0;
			for (int i = 0; i < HEADER_BYTES; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (adv) begin
			if (kind_s1 || res_emit) begin
				pos_q     <= '0;
				crc_run_q <= CRC_INIT;
				crc_ack_q <= CRC_INIT;
				type_q    <= '0;
				len_q     <= '0;
				crc_lo_q  <= '0;
				for (int i = 0; i < HEADER_BYTES; i++) begin
					hdr_q[i] <= '0;
				end
			end else begin
				pos_q <= pos_q + POS_W'(1);
				for (int i = 0; i < HEADER_BYTES; i++) begin
					if (in_hdr && (pos_q == POS_W'(i))) begin
						hdr_q[i] <= byte_s1;
					end
				end
				if (pos_q < POS_W'(ACK_HDR_BYTES)) begin
					crc_ack_q <= crc_ack_upd;
				end
				if (pos_q == POS_W'(HEADER_BYTES)) begin
					type_q <= byte_s1;
				end
				if (pos_q == POS_W'(HEADER_BYTES + 1)) begin
					len_q <= byte_s1;
				end
				if (in_hdr || (pos_q < data_end)) begin
					crc_run_q <= crc_run_upd;
				end
				if (!in_hdr && (pos_q == data_end)) begin
					crc_lo_q <= byte_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			job_beat_q  <= '0;
			job_ack_q   <= 1'b0;
		end else if (adv && res_emit) begin
			job_valid_q <= 1'b1;
			job_beat_q  <= '0;
			job_ack_q   <= res_ack;
		end else if (job_free) begin
			job_valid_q <= 1'b0;
		end else if (result.ready) begin
			job_beat_q <= job_beat_q + BEAT_W'(1);
		end
	end

	// Payload of the job; the header copy lets the next frame start at once.
	always_ff @(posedge clk) begin
		if (adv && res_emit) begin
			job_status_q <= res_status;
			job_crc_q    <= crc_ack_q;
			job_type_q   <= res_fields ? type_q : '0;
			job_len_q    <= res_fields ? len_eff : '0;
			job_off_q    <= res_fields ? off : '0;
			job_clr_q    <= res_clr;
			job_disp_q   <= res_disp;
			for (int i = 0; i < ACK_HDR_BYTES; i++) begin
				job_hdr_q[i] <= hdr_q[i];
			end
		end
	end

	assign result.valid            = job_valid_q;
	assign result.frame_status     = job_status_q;
	assign result.ack_valid        = job_ack_q;
	assign result.ack_last         = job_last;
	assign result.data_type        = job_type_q;
	assign result.payload_len      = job_len_q;
	assign result.register_offset  = job_off_q;
	assign result.clear_signals    = job_clr_q;
	assign result.dispatch_payload = job_disp_q;

	// Acknowledgement beats: six header bytes, then the reply CRC low and high.
	always_comb begin
		result.ack_byte = '0;
		if (job_ack_q) begin
			unique case (job_beat_q)
				3'd0:    result.ack_byte = job_hdr_q[0];
				3'd1:    result.ack_byte = job_hdr_q[1];
				3'd2:    result.ack_byte = job_hdr_q[2];
				3'd3:    result.ack_byte = job_hdr_q[3];
				3'd4:    result.ack_byte = job_hdr_q[4];
				3'd5:    result.ack_byte = job_hdr_q[5];
				3'd6:    result.ack_byte = job_crc_q[7:0];
				default: result.ack_byte = job_crc_q[15:8];
			endcase
		end
	end

endmodule

@@ sv/mwfr_checker.sv @@
// ---------------------------------------------------------------------------
// mwfr_checker
// Port-level checks on the result channel of the frame receiver.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mwfr_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_ready,
	input mwfr_pkg::status_t    frame_status,
	input logic                 ack_valid,
	input mwfr_pkg::byte_t      ack_byte,
	input logic                 ack_last,
	input mwfr_pkg::byte_t      data_type,
	input mwfr_pkg::byte_t      payload_len,
	input mwfr_pkg::word_t      register_offset,
	input logic                 clear_signals,
	input logic                 dispatch_payload
);
	import mwfr_pkg::*;

	logic rejected;
	assign rejected = (frame_status == STATUS_FOREIGN) || (frame_status == STATUS_RANGE) ||
		(frame_status == STATUS_TOO_LONG) || (frame_status == STATUS_CRC);

	// A stalled result transaction stays valid and keeps its status, ack byte and last flag.
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(ack_byte) && $stable(frame_status) && $stable(ack_last), "stalled result changed")

	// Acknowledgement beats follow each other without a gap until the last one.
	`ASSERT_NEXT(a_ack_run, clk, arst_n, res_valid && res_ready && ack_valid && !ack_last, res_valid && ack_valid, "acknowledgement run broken")

	// Only acknowledged frames carry acknowledgement bytes.
	`ASSERT_IMPLY(a_ack_status, clk, arst_n, res_valid && ack_valid, frame_status == STATUS_ACKED, "ack byte with non-ack status")

	// A lone status transaction is final, carries no byte and raises no flag.
	`ASSERT_IMPLY(a_single, clk, arst_n, res_valid && !ack_valid, ack_last && (ack_byte == 8'h00) && !clear_signals && !dispatch_payload && (frame_status != STATUS_ACKED), "bad single result")

	// A rejected frame reports no frame fields.
	`ASSERT_IMPLY(a_reject_zero, clk, arst_n, res_valid && rejected, (data_type == 8'h00) && (payload_len == 8'h00) && (register_offset == 16'h0000), "rejected frame with fields")

endmodule

bind modbus_write_frame_receiver_unit mwfr_checker u_mwfr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (result.valid),
	.res_ready        (result.ready),
	.frame_status     (result.frame_status),
	.ack_valid        (result.ack_valid),
	.ack_byte         (result.ack_byte),
	.ack_last         (result.ack_last),
	.data_type        (result.data_type),
	.payload_len      (result.payload_len),
	.register_offset  (result.register_offset),
	.clear_signals    (result.clear_signals),
	.dispatch_payload (result.dispatch_payload)
);
